@@ design/dbq_pkg.sv @@
`timescale 1ns / 1ps

package dbq_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT   = 3'd0,
        OP_PUSH_REAR    = 3'd1,
        OP_POP_FRONT    = 3'd2,
        OP_POP_REAR     = 3'd3,
        OP_REMOVE_SECOND = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_FEW  = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0]      value;
        logic                   vld;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count;
    } res_t;

    // (base + offset) mod DEPTH, with base < DEPTH and offset <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

@@ design/bounded_deque_with_remove_second_core.sv @@
`timescale 1ns / 1ps
// Bounded deque, 16 slots of 32 bits in a 1W/2R synchronous RAM.
// Order: push, refused or undefined op: result register, then output register;
//   pops and remove-second go through the registered RAM read (ST_RD) first.
// Throughput: pushes and refusals 1 per cycle unless m_ stalls; pops hold off s_.
// Reset: aresetn synchronous, active low; empties the queue, head to slot 0.
//   Slot contents are not cleared; only values from live slots are ever returned.

module bounded_deque_with_remove_second_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dbq_pkg::OP_W-1:0]            s_op,
    input  logic signed [dbq_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dbq_pkg::DATA_W-1:0]   m_out_value,
    output logic                                m_out_valid,
    output logic [dbq_pkg::STATUS_W-1:0]        m_status,
    output logic [dbq_pkg::COUNT_OUT_W-1:0]     m_count
);

    // RAM port signals
    logic                          mem_we;
    logic [dbq_pkg::ADDR_W-1:0]    mem_waddr;
    logic [dbq_pkg::DATA_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [dbq_pkg::ADDR_W-1:0]    mem_raddr_a;
    logic [dbq_pkg::ADDR_W-1:0]    mem_raddr_b;
    logic [dbq_pkg::DATA_W-1:0]    mem_rdata_a;
    logic [dbq_pkg::DATA_W-1:0]    mem_rdata_b;

    // result stage from the controller
    logic                          res_valid;
    logic                          res_ready;
    dbq_pkg::res_t                 res;

    // output register
    logic                          m_valid_reg;
    dbq_pkg::res_t                 m_res_reg;

    dbq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_value     (s_value),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    dbq_ram #(
        .DEPTH  (dbq_pkg::DEPTH),
        .ADDR_W (dbq_pkg::ADDR_W),
        .DATA_W (dbq_pkg::DATA_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Output register: the controller's result stage drains into it whenever it
    // is empty or its transfer completes this cycle, so one result can wait on
    // m_ while the next operation is already finished upstream.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_res_reg.value;
    assign m_out_valid = m_res_reg.vld;
    assign m_status    = m_res_reg.status;
    assign m_count     = m_res_reg.count;

    // a removed value always comes with a done status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_valid) |-> (m_status == dbq_pkg::STAT_OK))
        else $error("removed value reported with a refusal status");

    // refused or push results carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_valid) |-> (m_out_value == '0))
        else $error("nonzero value on a result without a removed item");

    // a successful pop holds off the next transfer during the RAM read state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && mem_re) |=> !s_ready)
        else $error("input accepted during a RAM read turn");

endmodule

@@ design/dbq_ram.sv @@
`timescale 1ns / 1ps

// One write port, two read ports, registered read data.
module dbq_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ design/dbq_ctrl.sv @@
`timescale 1ns / 1ps

module dbq_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dbq_pkg::OP_W-1:0]     s_op,
    input  logic [dbq_pkg::DATA_W-1:0]   s_value,
    output logic                         mem_we,
    output logic [dbq_pkg::ADDR_W-1:0]   mem_waddr,
    output logic [dbq_pkg::DATA_W-1:0]   mem_wdata,
    output logic                         mem_re,
    output logic [dbq_pkg::ADDR_W-1:0]   mem_raddr_a,
    output logic [dbq_pkg::ADDR_W-1:0]   mem_raddr_b,
    input  logic [dbq_pkg::DATA_W-1:0]   mem_rdata_a,
    input  logic [dbq_pkg::DATA_W-1:0]   mem_rdata_b,
    output logic                         res_valid,
    input  logic                         res_ready,
    output dbq_pkg::res_t                res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RD   = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [dbq_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [dbq_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          rm2_reg, rm2_next;
    logic                          res_valid_reg, res_valid_next;
    dbq_pkg::res_t                 res_reg, res_next;

    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          few;
    logic [dbq_pkg::ADDR_W-1:0]    head_dec;
    logic [dbq_pkg::ADDR_W-1:0]    second;

    assign full     = (cnt_reg == dbq_pkg::CNT_W'(dbq_pkg::DEPTH));
    assign empty    = (cnt_reg == '0);
    assign few      = (cnt_reg < dbq_pkg::CNT_W'(2));
    assign head_dec = (head_reg == '0) ? dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1)
                                       : head_reg - dbq_pkg::ADDR_W'(1);
    assign second   = dbq_pkg::ring_add(head_reg, dbq_pkg::CNT_W'(1));

    assign s_ready   = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = s_valid && s_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        rm2_next       = rm2_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = s_value;
        mem_re         = 1'b0;
        mem_raddr_a    = head_reg;
        mem_raddr_b    = second;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.value  = '0;
                    res_next.vld    = 1'b0;
                    res_next.status = dbq_pkg::STAT_OK;
                    res_next.count  = dbq_pkg::COUNT_OUT_W'(cnt_reg);
                    res_valid_next  = 1'b1;
                    case (s_op)
                        dbq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                res_next.status = dbq_pkg::STAT_FULL;
                            end else begin
                                head_next      = head_dec;
                                cnt_next       = cnt_reg + dbq_pkg::CNT_W'(1);
                                mem_we         = 1'b1;
                                mem_waddr      = head_dec;
                                res_next.count = dbq_pkg::COUNT_OUT_W'(cnt_next);
                            end
                        end
                        dbq_pkg::OP_PUSH_REAR: begin
                            if (full) begin
                                res_next.status = dbq_pkg::STAT_FULL;
                            end else begin
                                cnt_next       = cnt_reg + dbq_pkg::CNT_W'(1);
                                mem_we         = 1'b1;
                                mem_waddr      = dbq_pkg::ring_add(head_reg, cnt_reg);
                                res_next.count = dbq_pkg::COUNT_OUT_W'(cnt_next);
                            end
                        end
                        dbq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                res_next.status = dbq_pkg::STAT_FEW;
                            end else begin
                                mem_re         = 1'b1;
                                head_next      = second;
                                cnt_next       = cnt_reg - dbq_pkg::CNT_W'(1);
                                rm2_next       = 1'b0;
                                res_valid_next = 1'b0;
                                state_next     = ST_RD;
                            end
                        end
                        dbq_pkg::OP_POP_REAR: begin
                            if (empty) begin
                                res_next.status = dbq_pkg::STAT_FEW;
                            end else begin
                                mem_re         = 1'b1;
                                mem_raddr_a    = dbq_pkg::ring_add(head_reg,
                                                     cnt_reg - dbq_pkg::CNT_W'(1));
                                cnt_next       = cnt_reg - dbq_pkg::CNT_W'(1);
                                rm2_next       = 1'b0;
                                res_valid_next = 1'b0;
                                state_next     = ST_RD;
                            end
                        end
                        dbq_pkg::OP_REMOVE_SECOND: begin
                            if (few) begin
                                res_next.status = dbq_pkg::STAT_FEW;
                            end else begin
                                mem_re         = 1'b1;
                                head_next      = second;
                                cnt_next       = cnt_reg - dbq_pkg::CNT_W'(1);
                                rm2_next       = 1'b1;
                                res_valid_next = 1'b0;
                                state_next     = ST_RD;
                            end
                        end
                        default: begin
                            // undefined op: no state change, plain OK result
                        end
                    endcase
                end
            end
            ST_RD: begin
                // on remove-second, head already moved to the old second slot; front value drops in there
                res_next.vld    = 1'b1;
                res_next.status = dbq_pkg::STAT_OK;
                res_next.count  = dbq_pkg::COUNT_OUT_W'(cnt_reg);
                res_next.value  = rm2_reg ? mem_rdata_b : mem_rdata_a;
                res_valid_next  = 1'b1;
                mem_we          = rm2_reg;
                mem_waddr       = head_reg;
                mem_wdata       = mem_rdata_a;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            rm2_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            rm2_reg       <= rm2_next;
            res_valid_reg <= res_valid_next;
        end
        res_reg <= res_next;
    end

endmodule
